/* src/itd_pkg.sv */
// Shared types and constants for the image tile deduplicator.
// Depends on nothing; used by image_tile_deduplicator and itd_cell.
package itd_pkg;

	localparam int TileWDefault  = 8;
	localparam int TileHDefault  = 8;
	localparam int TilesXDefault = 8;
	localparam int TilesYDefault = 8;

	// Unique indexes and source tile numbers are six bits wide.
	localparam int IdxW = 6;

	// Configuration register indexes
	localparam logic RegTileBase    = 1'b0;
	localparam logic RegDedupEnable = 1'b1;

	// One ring cell: is this tile unique, and its unique index.
	typedef struct packed {
		logic            uniq;
		logic [IdxW-1:0] idx;
	} cell_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_CMP  = 3'b100
	} state_t;

endpackage

/* src/image_tile_deduplicator.sv */
// Image tile deduplicator top level: pixel load, ring of tile cells, compare sequencer.
// Depends on itd_pkg, itd_store and itd_cell.
//
// Load one 8-bit pixel per cycle in raster order with start while busy is low;
// busy stays low during the load, so pixels go in back to back. Pixels past
// TILES_X*TILE_W by TILES_Y*TILE_H are dropped. The beat with last high starts
// the tile walk and raises busy on the next cycle. The walk holds a ring of
// one cell per tile that rotates one place a cycle while no pixel compare is
// running; the head cell is the candidate tile. For tile i the ring makes one
// full turn, and with dedup enabled each earlier unique tile met before a
// match costs a pixel compare on the two read ports of the image store. One
// map beat per tile comes out on map_valid for a single cycle, in raster tile
// order; the receiver cannot stall it. end_of_map marks the final tile, and
// busy drops the cycle after it. Write the configuration registers only while
// busy is low.
module image_tile_deduplicator #(
	parameter int TILE_W  = itd_pkg::TileWDefault,
	parameter int TILE_H  = itd_pkg::TileHDefault,
	parameter int TILES_X = itd_pkg::TilesXDefault,
	parameter int TILES_Y = itd_pkg::TilesYDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  pixel,
	input  logic        last,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data,
	output logic        map_valid,
	output logic [15:0] map_value,
	output logic [5:0]  source_tile,
	output logic        is_new,
	output logic        end_of_map
);

	localparam int ImgW  = TILES_X * TILE_W;
	localparam int NPix  = ImgW * TILES_Y * TILE_H;
	localparam int NTile = TILES_X * TILES_Y;
	localparam int NPt   = TILE_W * TILE_H;
	localparam int AW    = (NPix > 1) ? $clog2(NPix) : 1;
	localparam int TW    = (NTile > 1) ? $clog2(NTile) : 1;
	localparam int XW    = (TILES_X > 1) ? $clog2(TILES_X) : 1;
	localparam int PXW   = (TILE_W > 1) ? $clog2(TILE_W) : 1;
	localparam int PW    = (NPt > 1) ? $clog2(NPt) : 1;
	localparam int IW    = itd_pkg::IdxW;
	// Base step from the last tile of a tile row to the first of the next
	localparam int RowStep = TILE_W + ImgW * (TILE_H - 1);
	// Offset step from the last pixel of a tile row to the first of the next
	localparam int LineStep = ImgW - TILE_W + 1;

	// Configuration
	logic [15:0] tile_base_q;
	logic        dedup_q;

	// Load side
	logic [AW:0] pix_cnt_q;
	logic        accept;
	logic        store_we;

	// Walk control
	itd_pkg::state_t state_q;
	logic [TW-1:0]   t_q, i_q;
	logic [XW-1:0]   tx_q, ix_q;
	logic [AW-1:0]   tbase_q, ibase_q;
	logic            found_q;
	logic [IW-1:0]   match_idx_q;
	logic [IW:0]     ucount_q;

	// Compare sequencer
	logic [AW-1:0]   off_q;
	logic [PXW-1:0]  px_q;
	logic [PW-1:0]   pcnt_q;
	logic            issuing_q;
	logic            rd_v_s1, rd_last_s1;
	logic [7:0]      rd_a, rd_b;

	// Ring
	itd_pkg::cell_t  ring [NTile];
	itd_pkg::cell_t  head, new_cell;
	logic            shift, wr;

	logic at_i, try_cmp, enter_cmp, mism, hit, adv, t_last, wrap, walk_done;
	logic pix_last;

	assign busy     = (state_q != itd_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign store_we = accept && (pix_cnt_q < (AW+1)'(NPix));

	assign head      = ring[0];
	assign at_i      = (t_q == i_q);
	assign try_cmp   = !found_q && dedup_q && head.uniq && (t_q < i_q);
	assign enter_cmp = (state_q == itd_pkg::ST_SCAN) && !at_i && try_cmp;
	assign mism      = (state_q == itd_pkg::ST_CMP) && rd_v_s1 && (rd_a != rd_b);
	assign hit       = (state_q == itd_pkg::ST_CMP) && rd_v_s1 && (rd_a == rd_b) && rd_last_s1;
	assign adv       = ((state_q == itd_pkg::ST_SCAN) && !enter_cmp) || mism || hit;
	assign t_last    = (t_q == TW'(NTile - 1));
	assign wrap      = adv && t_last;
	assign walk_done = wrap && (i_q == TW'(NTile - 1));
	assign pix_last  = (pcnt_q == PW'(NPt - 1));

	// When the walk reaches tile i, the tail takes a new cell for tile i in place of the head.
	assign wr             = (state_q == itd_pkg::ST_SCAN) && at_i;
	assign new_cell.uniq  = !found_q;
	assign new_cell.idx   = ucount_q[IW-1:0];
	assign shift          = adv;

	generate
		for (genvar k = 0; k < NTile; k++) begin : g_ring
			itd_pkg::cell_t din;
			if (k == NTile - 1) begin : g_tail
				assign din = wr ? new_cell : ring[0];
			end else begin : g_mid
				assign din = ring[k+1];
			end
			itd_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.din   (din),
				.dout  (ring[k])
			);
		end
	endgenerate

	itd_store #(
		.Depth (NPix),
		.AddrW (AW)
	) u_store (
		.clk     (clk),
		.we      (store_we),
		.waddr   (pix_cnt_q[AW-1:0]),
		.wdata   (pixel),
		.raddr_a (ibase_q + off_q),
		.raddr_b (tbase_q + off_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Map beat: one per tile, when the ring head reaches the tile itself
	assign map_valid   = wr;
	assign map_value   = tile_base_q + 16'(found_q ? match_idx_q : ucount_q[IW-1:0]);
	assign source_tile = 6'(i_q);
	assign is_new      = !found_q;
	assign end_of_map  = (i_q == TW'(NTile - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_base_q <= '0;
			dedup_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				itd_pkg::RegTileBase:    tile_base_q <= cfg_data;
				itd_pkg::RegDedupEnable: dedup_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itd_pkg::ST_IDLE;
			pix_cnt_q   <= '0;
			t_q         <= '0;
			i_q         <= '0;
			tx_q        <= '0;
			ix_q        <= '0;
			tbase_q     <= '0;
			ibase_q     <= '0;
			found_q     <= 1'b0;
			ucount_q    <= '0;
			off_q       <= '0;
			px_q        <= '0;
			pcnt_q      <= '0;
			issuing_q   <= 1'b0;
			rd_v_s1     <= 1'b0;
			match_idx_q <= '0;
		end else begin
			if (store_we) begin
				pix_cnt_q <= pix_cnt_q + 1'b1;
			end
			// Start the walk on the last beat
			if (accept && last) begin
				state_q  <= itd_pkg::ST_SCAN;
				t_q      <= '0;
				i_q      <= '0;
				tx_q     <= '0;
				ix_q     <= '0;
				tbase_q  <= '0;
				ibase_q  <= '0;
				found_q  <= 1'b0;
				ucount_q <= '0;
			end
			if (wr && !found_q) begin
				ucount_q <= ucount_q + 1'b1;
			end
			if (hit) begin
				found_q     <= 1'b1;
				match_idx_q <= head.idx;
			end
			// Advance the candidate tile with the ring
			if (adv) begin
				if (t_last) begin
					t_q     <= '0;
					tx_q    <= '0;
					tbase_q <= '0;
				end else begin
					t_q <= t_q + 1'b1;
					if (tx_q == XW'(TILES_X - 1)) begin
						tx_q    <= '0;
						tbase_q <= tbase_q + AW'(RowStep);
					end else begin
						tx_q    <= tx_q + 1'b1;
						tbase_q <= tbase_q + AW'(TILE_W);
					end
				end
			end
			// A full turn ends tile i; move on to the next tile
			if (wrap) begin
				found_q <= 1'b0;
				i_q     <= i_q + 1'b1;
				if (ix_q == XW'(TILES_X - 1)) begin
					ix_q    <= '0;
					ibase_q <= ibase_q + AW'(RowStep);
				end else begin
					ix_q    <= ix_q + 1'b1;
					ibase_q <= ibase_q + AW'(TILE_W);
				end
			end
			if (walk_done) begin
				state_q   <= itd_pkg::ST_IDLE;
				pix_cnt_q <= '0;
			end
			// Pixel compare: issue addresses, check the registered bytes in the next cycle
			if (enter_cmp) begin
				state_q   <= itd_pkg::ST_CMP;
				off_q     <= '0;
				px_q      <= '0;
				pcnt_q    <= '0;
				issuing_q <= 1'b1;
			end else if ((state_q == itd_pkg::ST_CMP) && issuing_q) begin
				pcnt_q <= pcnt_q + 1'b1;
				if (pix_last) begin
					issuing_q <= 1'b0;
				end
				if (px_q == PXW'(TILE_W - 1)) begin
					px_q  <= '0;
					off_q <= off_q + AW'(LineStep);
				end else begin
					px_q  <= px_q + 1'b1;
					off_q <= off_q + 1'b1;
				end
			end
			if ((state_q == itd_pkg::ST_CMP) && adv) begin
				state_q   <= itd_pkg::ST_SCAN;
				issuing_q <= 1'b0;
			end
			rd_v_s1 <= (state_q == itd_pkg::ST_CMP) && issuing_q && !adv;
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= pix_last;
	end

`ifndef SYNTHESIS
	a_beat_busy : assert property (@(posedge clk) disable iff (!arst_n)
		map_valid |-> busy)
		else $error("map beat outside the walk");
	a_end_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(map_valid && end_of_map) |=> !busy)
		else $error("walk did not end after the final map beat");
	a_hit_dedup : assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (dedup_q && !found_q))
		else $error("match taken with dedup off or already found");
	a_cmp_scan : assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == itd_pkg::ST_CMP))
		else $error("compare data valid outside a compare");
`endif

endmodule

/* src/itd_store.sv */
// Image byte store: one write port, two registered read ports.
// Depends on nothing.
module itd_store #(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic [AddrW-1:0] raddr_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [7:0]       rdata_a,
	output logic [7:0]       rdata_b
);

	logic [7:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/itd_cell.sv */
// One cell of the rotating tile ring; takes its neighbor's entry on each shift.
// Depends on itd_pkg.
module itd_cell (
	input  logic            clk,
	input  logic            shift,
	input  itd_pkg::cell_t  din,
	output itd_pkg::cell_t  dout
);

	itd_pkg::cell_t cell_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			cell_q <= din;
		end
	end

	assign dout = cell_q;

endmodule

/* tb/image_tile_deduplicator_tb.sv */
// Self-checking testbench for image_tile_deduplicator: loads whole and partial images,
// predicts every tile map beat and checks each one field by field as it comes out.
// Depends on itd_pkg and the image_tile_deduplicator RTL under src.
module image_tile_deduplicator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TileSide = 8;
	localparam int TilesAcross = 8;
	localparam int ImgW = TileSide * TilesAcross;
	localparam int ImgPixels = ImgW * ImgW;
	localparam int TileCount = TilesAcross * TilesAcross;
	localparam int StallLimit = 50000;

	// How the pixels of an image are made up.
	typedef enum int {
		PAT_ZERO,
		PAT_FULL,
		PAT_RAND,
		PAT_MOD4,
		PAT_LASTPIX,
		PAT_LIB
	} pattern_t;

	typedef struct {
		pattern_t    pat;
		int          count;
		logic        write_regs;
		logic [15:0] base;
		logic        dedup;
		int          want_new;   // new tiles the walk must report, -1 if only predicted
	} image_row_t;

	typedef struct {
		logic [15:0] map_value;
		logic [5:0]  source_tile;
		logic        is_new;
		logic        end_of_map;
	} map_beat_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  pixel;
	logic        last;
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_data;
	logic        map_valid;
	logic [15:0] map_value;
	logic [5:0]  source_tile;
	logic        is_new;
	logic        end_of_map;

	image_tile_deduplicator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .last(last),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.map_valid(map_valid), .map_value(map_value), .source_tile(source_tile),
		.is_new(is_new), .end_of_map(end_of_map)
	);

	// Shadow copy of the block: image store, load position and registers.
	logic [7:0]  shadow_image [ImgPixels];
	int          shadow_count;
	logic [15:0] shadow_base;
	logic        shadow_dedup;

	map_beat_t   pending_maps[$];
	int          errors;
	int          new_tiles_seen;
	int          idle_pct;
	int          stall_cycles;

	// Tile library for random images: a few contents shared among tile slots.
	logic [7:0]  tile_lib [4][TileSide*TileSide];
	int          slot_pick [TileCount];

	image_row_t  directed_rows [8] = '{
		'{PAT_ZERO,    ImgPixels,     1'b0, 16'h0000, 1'b1, 1},   // reset registers
		'{PAT_RAND,    ImgPixels,     1'b1, 16'h0000, 1'b1, -1},
		'{PAT_FULL,    ImgPixels + 5, 1'b1, 16'h0007, 1'b1, 1},   // excess pixels
		'{PAT_RAND,    100,           1'b1, 16'h0000, 1'b1, -1},  // short image
		'{PAT_ZERO,    ImgPixels,     1'b1, 16'hFFFF, 1'b0, 64},  // no dedup, wrap
		'{PAT_MOD4,    ImgPixels,     1'b1, 16'h1234, 1'b1, 4},
		'{PAT_LASTPIX, ImgPixels,     1'b1, 16'h0000, 1'b1, 2},   // differ at last pixel
		'{PAT_RAND,    1,             1'b1, 16'hFFC0, 1'b1, -1}   // one-pixel image
	};

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Raster address of pixel k of tile t.
	function automatic int tile_pixel(int t, int k);
		return ((t / TilesAcross) * TileSide + k / TileSide) * ImgW
			+ (t % TilesAcross) * TileSide + k % TileSide;
	endfunction

	// Work out the map beats of one tile walk over the shadow image.
	function automatic void walk_tiles();
		int         uniq [TileCount];
		int         n_uniq;
		int         hit;
		logic       same;
		map_beat_t  b;
		n_uniq = 0;
		for (int t = 0; t < TileCount; t++) begin
			hit = -1;
			if (shadow_dedup) begin
				for (int j = 0; j < n_uniq && hit < 0; j++) begin
					same = 1'b1;
					for (int k = 0; k < TileSide * TileSide; k++) begin
						if (shadow_image[tile_pixel(t, k)]
								!= shadow_image[tile_pixel(uniq[j], k)])
							same = 1'b0;
					end
					if (same)
						hit = j;
				end
			end
			b.is_new = (hit < 0);
			if (hit < 0) begin
				hit = n_uniq;
				uniq[n_uniq] = t;
				n_uniq++;
			end
			b.map_value = 16'(hit) + shadow_base;
			b.source_tile = 6'(t);
			b.end_of_map = (t == TileCount - 1);
			pending_maps.push_back(b);
		end
	endfunction

	function automatic void absorb_pixel(logic [7:0] px, logic lst);
		if (shadow_count < ImgPixels) begin
			shadow_image[shadow_count] = px;
			shadow_count++;
		end
		if (lst) begin
			walk_tiles();
			shadow_count = 0;
		end
	endfunction

	function automatic logic [7:0] make_pixel(pattern_t pat, int p);
		int t;
		int k;
		t = ((p / ImgW) / TileSide % TilesAcross) * TilesAcross + (p % ImgW) / TileSide;
		k = ((p / ImgW) % TileSide) * TileSide + p % TileSide;
		case (pat)
			PAT_ZERO:    return 8'h00;
			PAT_FULL:    return 8'hFF;
			PAT_RAND:    return 8'($urandom);
			PAT_MOD4:    return 8'((t % 4) * 64 + k);
			PAT_LASTPIX: return (k == TileSide * TileSide - 1) ? 8'(t % 2) : 8'h5A;
			default: begin
				if (slot_pick[t] < 0)
					return 8'($urandom);
				return tile_lib[slot_pick[t]][k];
			end
		endcase
	endfunction

	// Send one pixel beat, idling first at the current rate; hold until accepted.
	task automatic send_pixel(logic [7:0] px, logic lst);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				pixel <= 8'($urandom);
				last <= 1'($urandom);
				continue;
			end
			start <= 1'b1;
			pixel <= px;
			last <= lst;
			@(posedge clk);
			if (!busy) begin
				absorb_pixel(px, lst);
				break;
			end
		end
	endtask

	// Wait out the walk: no beat pending and busy low, then a few spare cycles.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_maps.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] base, logic dd);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= itd_pkg::RegTileBase;
		cfg_data <= base;
		@(negedge clk);
		cfg_addr <= itd_pkg::RegDedupEnable;
		cfg_data <= {15'($urandom), dd};
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_base = base;
		shadow_dedup = dd;
	endtask

	task automatic load_image(pattern_t pat, int count);
		for (int p = 0; p < count; p++)
			send_pixel(make_pixel(pat, p), p == count - 1);
	endtask

	// Check every map beat against the oldest pending prediction.
	always @(posedge clk) begin
		map_beat_t w;
		if (arst_n && map_valid) begin
			if (is_new)
				new_tiles_seen++;
			if (pending_maps.size() == 0) begin
				$display("%t: map beat with nothing pending: value %h tile %0d",
					$realtime, map_value, source_tile);
				errors++;
			end else begin
				w = pending_maps.pop_front();
				if (map_value !== w.map_value || source_tile !== w.source_tile
						|| is_new !== w.is_new || end_of_map !== w.end_of_map) begin
					$display({"%t: map beat mismatch: expected value %h tile %0d",
						" new %b end %b, got value %h tile %0d new %b end %b"},
						$realtime, w.map_value, w.source_tile, w.is_new, w.end_of_map,
						map_value, source_tile, is_new, end_of_map);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no pixel accepted and no map beat out.
	always @(posedge clk) begin
		if (!arst_n || map_valid || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] base;
		int          n;
		errors = 0;
		new_tiles_seen = 0;
		stall_cycles = 0;
		idle_pct = 0;
		shadow_count = 0;
		shadow_base = 16'h0000;
		shadow_dedup = 1'b1;
		start = 1'b0;
		pixel = 8'h00;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = itd_pkg::RegTileBase;
		cfg_data = 16'h0000;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed images: extremes, excess and short loads, dedup on and off.
		for (int r = 0; r < $size(directed_rows); r++) begin
			idle_pct = (r % 3 == 0) ? 0 : ((r % 3 == 1) ? 78 : 31);
			if (directed_rows[r].write_regs)
				set_regs(directed_rows[r].base, directed_rows[r].dedup);
			new_tiles_seen = 0;
			load_image(directed_rows[r].pat, directed_rows[r].count);
			drain();
			if (directed_rows[r].want_new >= 0
					&& new_tiles_seen != directed_rows[r].want_new) begin
				$display("%t: image %0d new tile count: expected %0d, got %0d",
					$realtime, r, directed_rows[r].want_new, new_tiles_seen);
				errors++;
			end
		end

		// Random images built from a small tile library so that duplicates are common.
		for (int r = 0; r < 6; r++) begin
			case (r % 3)
				0: idle_pct = 0;
				1: idle_pct = 78;
				default: idle_pct = 31;
			endcase
			case ($urandom_range(3))
				0: base = 16'h0000;
				1: base = 16'hFFFF;
				default: base = 16'($urandom);
			endcase
			set_regs(base, $urandom_range(3) != 0);
			for (int s = 0; s < 4; s++)
				for (int k = 0; k < TileSide * TileSide; k++)
					tile_lib[s][k] = 8'($urandom);
			// Half the time, library entry 1 copies entry 0 in all but its final pixel.
			if ($urandom_range(1))
				for (int k = 0; k < TileSide * TileSide - 1; k++)
					tile_lib[1][k] = tile_lib[0][k];
			for (int t = 0; t < TileCount; t++)
				slot_pick[t] = ($urandom_range(7) == 0) ? -1 : int'($urandom_range(3));
			case ($urandom_range(4))
				0: n = $urandom_range(1, ImgPixels - 1);
				1: n = ImgPixels + $urandom_range(1, 8);
				default: n = ImgPixels;
			endcase
			load_image(PAT_LIB, n);
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && pending_maps.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
